### src/setc_pkg.sv
// Shared types, constants and the gain table for the edge-trigger capture block.
// No dependencies; used by every module under src.
`default_nettype none

package setc_pkg;

    // Screen and converter geometry
    localparam int SAMPLE_BITS         = 12;
    localparam int SCREEN_WIDTH        = 128;
    localparam int SCREEN_HEIGHT       = 128;
    localparam int PIXELS_PER_DIVISION = 20;

    localparam int ROW_BITS    = $clog2(SCREEN_HEIGHT);
    localparam int PAIR_COUNT  = SCREEN_WIDTH / 2;
    localparam int PAIR_BITS   = $clog2(PAIR_COUNT);
    localparam int HALF_WIDTH  = SCREEN_WIDTH / 2;
    localparam int HALF_HEIGHT = SCREEN_HEIGHT / 2;

    // Unsigned Q0.16 gain, product and rounded magnitude widths
    localparam int GAIN_BITS  = 16;
    localparam int FRAC_BITS  = 16;
    localparam int PROD_BITS  = SAMPLE_BITS + GAIN_BITS;
    localparam int ROUND_BITS = PROD_BITS + 1 - FRAC_BITS;

    // Configuration port
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 12;
    localparam int SCALE_BITS     = 3;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_TRIGGER_FALLING = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_VOLTS_SCALE     = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_TRIGGER_LEVEL   = 2'd2;

    localparam logic [CFG_DATA_BITS-1:0] LEVEL_RESET = 12'd2048;

    // Request function codes
    localparam logic FUNC_STORE   = 1'b0;
    localparam logic FUNC_CAPTURE = 1'b1;

    // Volts-per-division selects
    localparam logic [SCALE_BITS-1:0] SCALE_0V1 = 3'd0;
    localparam logic [SCALE_BITS-1:0] SCALE_0V2 = 3'd1;
    localparam logic [SCALE_BITS-1:0] SCALE_0V5 = 3'd2;
    localparam logic [SCALE_BITS-1:0] SCALE_1V0 = 3'd3;

    // gain = round(3.3 * ppd / (2^bits * V/div) * 2^16), volts in tenths
    localparam longint unsigned GAIN_NUM   = 64'd33 * PIXELS_PER_DIVISION * 64'd131072;
    localparam longint unsigned FULL_SCALE = 64'd1 << SAMPLE_BITS;
    localparam longint unsigned GAIN_MAX   = (64'd1 << GAIN_BITS) - 64'd1;

    localparam longint unsigned GAIN_RAW_0V1 = (GAIN_NUM + FULL_SCALE * 1) / (2 * FULL_SCALE * 1);
    localparam longint unsigned GAIN_RAW_0V2 = (GAIN_NUM + FULL_SCALE * 2) / (2 * FULL_SCALE * 2);
    localparam longint unsigned GAIN_RAW_0V5 = (GAIN_NUM + FULL_SCALE * 5) / (2 * FULL_SCALE * 5);
    localparam longint unsigned GAIN_RAW_1V0 = (GAIN_NUM + FULL_SCALE * 10) / (2 * FULL_SCALE * 10);
    localparam longint unsigned GAIN_RAW_2V0 = (GAIN_NUM + FULL_SCALE * 20) / (2 * FULL_SCALE * 20);

    localparam logic [GAIN_BITS-1:0] GAIN_0V1 =
        (GAIN_RAW_0V1 > GAIN_MAX) ? GAIN_BITS'(GAIN_MAX) : GAIN_BITS'(GAIN_RAW_0V1);
    localparam logic [GAIN_BITS-1:0] GAIN_0V2 =
        (GAIN_RAW_0V2 > GAIN_MAX) ? GAIN_BITS'(GAIN_MAX) : GAIN_BITS'(GAIN_RAW_0V2);
    localparam logic [GAIN_BITS-1:0] GAIN_0V5 =
        (GAIN_RAW_0V5 > GAIN_MAX) ? GAIN_BITS'(GAIN_MAX) : GAIN_BITS'(GAIN_RAW_0V5);
    localparam logic [GAIN_BITS-1:0] GAIN_1V0 =
        (GAIN_RAW_1V0 > GAIN_MAX) ? GAIN_BITS'(GAIN_MAX) : GAIN_BITS'(GAIN_RAW_1V0);
    localparam logic [GAIN_BITS-1:0] GAIN_2V0 =
        (GAIN_RAW_2V0 > GAIN_MAX) ? GAIN_BITS'(GAIN_MAX) : GAIN_BITS'(GAIN_RAW_2V0);

    // Selects above the 1 V/div code use the 2 V/div gain
    function automatic logic [GAIN_BITS-1:0] gain_lookup(input logic [SCALE_BITS-1:0] sel);
        logic [GAIN_BITS-1:0] g;
        case (sel)
            SCALE_0V1: g = GAIN_0V1;
            SCALE_0V2: g = GAIN_0V2;
            SCALE_0V5: g = GAIN_0V5;
            SCALE_1V0: g = GAIN_1V0;
            default:   g = GAIN_2V0;
        endcase
        return g;
    endfunction

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_BASE,
        ST_ISSUE_A,
        ST_ISSUE_B,
        ST_WAIT
    } state_t;

    typedef struct packed {
        logic search_init;
        logic search_run;
        logic emit_init;
        logic read_first;
        logic read_second;
    } cmd_t;

    typedef struct packed {
        logic search_done;
        logic out_free;
        logic pair_done;
        logic last_pair;
    } status_t;

endpackage

`default_nettype wire

### src/setc_store.sv
// Circular sample store: one write port, one registered read port, write pointer.
// A fill count stands in for clearing; unwritten entries read as zero. Uses setc_pkg.
`default_nettype none

module setc_store #(
    parameter int BUFFER_DEPTH = 2048
) (
    input  wire                                  aclk,
    input  wire                                  aresetn,
    input  wire                                  wr_en,
    input  wire  [setc_pkg::SAMPLE_BITS-1:0]     wr_data,
    input  wire                                  rd_en,
    input  wire  [$clog2(BUFFER_DEPTH)-1:0]      rd_addr,
    output logic [setc_pkg::SAMPLE_BITS-1:0]     rd_data,
    output logic [$clog2(BUFFER_DEPTH)-1:0]      wr_ptr
);

    localparam int AW = $clog2(BUFFER_DEPTH);
    localparam int FW = $clog2(BUFFER_DEPTH + 1);
    localparam int SB = setc_pkg::SAMPLE_BITS;

    logic [SB-1:0] mem [BUFFER_DEPTH];

    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FW-1:0] fill_reg, fill_next;
    logic [SB-1:0] rd_word_reg;
    logic          rd_hit_reg;

    // Writes start at entry 0 and run in order, so entries below fill are written
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        fill_next   = fill_reg;
        if (wr_en) begin
            if (wr_ptr_reg == AW'(BUFFER_DEPTH - 1)) begin
                wr_ptr_next = '0;
            end else begin
                wr_ptr_next = wr_ptr_reg + 1'b1;
            end
            if (fill_reg != FW'(BUFFER_DEPTH)) begin
                fill_next = fill_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= AW'(BUFFER_DEPTH - 1);
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_ptr_next] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_word_reg <= mem[rd_addr];
            rd_hit_reg  <= (FW'(rd_addr) < fill_reg);
        end
    end

    assign rd_data = rd_hit_reg ? rd_word_reg : '0;
    assign wr_ptr  = wr_ptr_reg;

endmodule

`default_nettype wire

### src/setc_ctrl.sv
// Capture sequencer: trigger search, base setup, then two store reads per result.
// Drives setc_pkg::cmd_t to the datapath and reads back setc_pkg::status_t.
`default_nettype none

module setc_ctrl (
    input  wire                aclk,
    input  wire                aresetn,
    input  wire                capture_req,
    input  setc_pkg::status_t  status,
    output setc_pkg::cmd_t     cmd,
    output logic               s_ready
);

    setc_pkg::state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            setc_pkg::ST_IDLE: begin
                if (capture_req) begin
                    state_next = setc_pkg::ST_SEARCH;
                end
            end
            setc_pkg::ST_SEARCH: begin
                if (status.search_done) begin
                    state_next = setc_pkg::ST_BASE;
                end
            end
            setc_pkg::ST_BASE: begin
                state_next = setc_pkg::ST_ISSUE_A;
            end
            setc_pkg::ST_ISSUE_A: begin
                if (status.out_free) begin
                    state_next = setc_pkg::ST_ISSUE_B;
                end
            end
            setc_pkg::ST_ISSUE_B: begin
                state_next = setc_pkg::ST_WAIT;
            end
            setc_pkg::ST_WAIT: begin
                if (status.pair_done) begin
                    state_next = status.last_pair ? setc_pkg::ST_IDLE : setc_pkg::ST_ISSUE_A;
                end
            end
            default: begin
                state_next = setc_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        case (state_reg)
            setc_pkg::ST_IDLE: begin
                s_ready         = 1'b1;
                cmd.search_init = capture_req;
            end
            setc_pkg::ST_SEARCH: begin
                cmd.search_run = 1'b1;
            end
            setc_pkg::ST_BASE: begin
                cmd.emit_init = 1'b1;
            end
            setc_pkg::ST_ISSUE_A: begin
                // hold the pair back until the output register is empty
                cmd.read_first = status.out_free;
            end
            setc_pkg::ST_ISSUE_B: begin
                cmd.read_second = 1'b1;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= setc_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

### src/setc_dpath.sv
// Datapath: config registers, store addressing, trigger compare, row scaling
// pipeline and output register. Uses setc_pkg; reads the store through its rd_* ports.
`default_nettype none

module setc_dpath #(
    parameter int BUFFER_DEPTH = 2048
) (
    input  wire                                    aclk,
    input  wire                                    aresetn,
    input  wire                                    cfg_valid,
    input  wire  [setc_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  wire  [setc_pkg::CFG_DATA_BITS-1:0]     cfg_data,
    input  setc_pkg::cmd_t                         cmd,
    output setc_pkg::status_t                      status,
    input  wire  [$clog2(BUFFER_DEPTH)-1:0]        wr_ptr,
    output logic                                   rd_en,
    output logic [$clog2(BUFFER_DEPTH)-1:0]        rd_addr,
    input  wire  [setc_pkg::SAMPLE_BITS-1:0]       rd_data,
    input  wire                                    m_ready,
    output logic                                   m_valid,
    output logic [setc_pkg::PAIR_BITS-1:0]         m_pair_index,
    output logic [setc_pkg::ROW_BITS-1:0]          m_y_first,
    output logic [setc_pkg::ROW_BITS-1:0]          m_y_second,
    output logic                                   m_last
);

    localparam int AW          = $clog2(BUFFER_DEPTH);
    localparam int SB          = setc_pkg::SAMPLE_BITS;
    localparam int RB          = setc_pkg::ROW_BITS;
    localparam int PB          = setc_pkg::PAIR_BITS;
    localparam int HALF_DEPTH  = BUFFER_DEPTH / 2;
    localparam int ISSUE_BITS  = $clog2(HALF_DEPTH + 2);
    localparam int CHECK_BITS  = $clog2(HALF_DEPTH + 1);
    localparam int PROD_BITS   = setc_pkg::PROD_BITS;
    localparam int ROUND_BITS  = setc_pkg::ROUND_BITS;
    localparam int HW          = setc_pkg::HALF_WIDTH;

    localparam logic [PROD_BITS:0]    ROUND_HALF = (PROD_BITS + 1)'(1) << (setc_pkg::FRAC_BITS - 1);
    localparam logic [ROUND_BITS-1:0] POS_LIMIT  = ROUND_BITS'(setc_pkg::HALF_HEIGHT);
    localparam logic [ROUND_BITS-1:0] NEG_LIMIT  =
        ROUND_BITS'(setc_pkg::SCREEN_HEIGHT - 1 - setc_pkg::HALF_HEIGHT);
    localparam logic [RB-1:0] ROW_MID = RB'(setc_pkg::HALF_HEIGHT);
    localparam logic [RB-1:0] ROW_TOP = RB'(setc_pkg::SCREEN_HEIGHT - 1);

    // Configuration
    logic                             falling_reg, falling_next;
    logic [setc_pkg::SCALE_BITS-1:0]  scale_reg, scale_next;
    logic [SB-1:0]                    level_reg, level_next;

    // Search state
    logic [AW-1:0]         addr_reg, addr_next;
    logic [AW-1:0]         start_reg;
    logic [ISSUE_BITS-1:0] issue_cnt_reg, issue_cnt_next;
    logic [CHECK_BITS-1:0] check_cnt_reg, check_cnt_next;
    logic                  srch_v_reg;
    logic [AW-1:0]         srch_addr_reg;
    logic                  have_cur_reg, have_cur_next;
    logic [SB-1:0]         cur_data_reg;
    logic [AW-1:0]         cur_addr_reg;
    logic                  found_reg, found_next;
    logic [AW-1:0]         trig_reg;

    // Row pipeline
    logic                  e1_v_reg, e1_second_reg;
    logic                  e2_v_reg, e2_second_reg, e2_neg_reg;
    logic [PROD_BITS-1:0]  prod_reg;
    logic                  e3_v_reg, e3_second_reg;
    logic [RB-1:0]         row_reg;
    logic [RB-1:0]         first_hold_reg;

    // Output
    logic [PB-1:0]         pair_reg, pair_next;
    logic                  m_valid_reg, m_valid_next;
    logic [PB-1:0]         m_pair_reg;
    logic [RB-1:0]         m_y_first_reg, m_y_second_reg;
    logic                  m_last_reg;

    logic                  srch_issue, emit_issue, search_done, pair_load, hit, check_ok;
    logic [AW-1:0]         start_calc, base_calc, trig_sel, addr_dec, addr_inc;
    logic [SB:0]           diff;
    logic                  diff_neg;
    logic [SB-1:0]         mag;
    logic [PROD_BITS:0]    rounded;
    logic [ROUND_BITS-1:0] rnd;
    logic [RB-1:0]         row_calc;

    // ---------------- configuration ----------------
    always_comb begin
        falling_next = falling_reg;
        scale_next   = scale_reg;
        level_next   = level_reg;
        if (cfg_valid) begin
            case (cfg_index)
                setc_pkg::CFG_TRIGGER_FALLING: falling_next = cfg_data[0];
                setc_pkg::CFG_VOLTS_SCALE:     scale_next   = cfg_data[setc_pkg::SCALE_BITS-1:0];
                setc_pkg::CFG_TRIGGER_LEVEL:   level_next   = cfg_data[SB-1:0];
                default: begin
                    falling_next = falling_reg;
                end
            endcase
        end
    end

    // ---------------- addressing ----------------
    always_comb begin
        if (wr_ptr >= AW'(HW)) begin
            start_calc = wr_ptr - AW'(HW);
        end else begin
            start_calc = wr_ptr + AW'(BUFFER_DEPTH - HW);
        end
        trig_sel = found_reg ? trig_reg : start_reg;
        if (trig_sel >= AW'(HW)) begin
            base_calc = trig_sel - AW'(HW);
        end else begin
            base_calc = trig_sel + AW'(BUFFER_DEPTH - HW);
        end
        addr_dec = (addr_reg == '0) ? AW'(BUFFER_DEPTH - 1) : addr_reg - 1'b1;
        addr_inc = (addr_reg == AW'(BUFFER_DEPTH - 1)) ? '0 : addr_reg + 1'b1;
    end

    assign search_done = found_reg || (check_cnt_reg == CHECK_BITS'(HALF_DEPTH));
    assign srch_issue  = cmd.search_run && !found_reg &&
                         (issue_cnt_reg != ISSUE_BITS'(HALF_DEPTH + 1));
    assign emit_issue  = cmd.read_first || cmd.read_second;
    assign rd_en       = srch_issue || emit_issue;
    assign rd_addr     = addr_reg;

    always_comb begin
        addr_next      = addr_reg;
        issue_cnt_next = issue_cnt_reg;
        if (cmd.search_init) begin
            addr_next      = start_calc;
            issue_cnt_next = '0;
        end else if (cmd.emit_init) begin
            addr_next = base_calc;
        end else if (srch_issue) begin
            addr_next      = addr_dec;
            issue_cnt_next = issue_cnt_reg + 1'b1;
        end else if (emit_issue) begin
            addr_next = addr_inc;
        end
    end

    // ---------------- trigger compare ----------------
    // Data now arriving is the sample just older than cur_data_reg.
    always_comb begin
        if (falling_reg) begin
            hit = (cur_data_reg <= level_reg) && (rd_data > level_reg);
        end else begin
            hit = (cur_data_reg >= level_reg) && (rd_data < level_reg);
        end
        check_ok = srch_v_reg && have_cur_reg && !search_done;
    end

    always_comb begin
        check_cnt_next = check_cnt_reg;
        have_cur_next  = have_cur_reg;
        found_next     = found_reg;
        if (cmd.search_init) begin
            check_cnt_next = '0;
            have_cur_next  = 1'b0;
            found_next     = 1'b0;
        end else if (srch_v_reg) begin
            have_cur_next = 1'b1;
            if (check_ok) begin
                check_cnt_next = check_cnt_reg + 1'b1;
                found_next     = hit;
            end
        end
    end

    // ---------------- row scaling ----------------
    always_comb begin
        diff     = {1'b0, rd_data} - {1'b0, level_reg};
        diff_neg = diff[SB];
        mag      = diff_neg ? SB'(-diff) : diff[SB-1:0];
        rounded  = (PROD_BITS + 1)'(prod_reg) + ROUND_HALF;
        rnd      = rounded[PROD_BITS:setc_pkg::FRAC_BITS];
        if (!e2_neg_reg) begin
            row_calc = (rnd > POS_LIMIT) ? '0 : ROW_MID - rnd[RB-1:0];
        end else begin
            row_calc = (rnd > NEG_LIMIT) ? ROW_TOP : ROW_MID + rnd[RB-1:0];
        end
    end

    // ---------------- output ----------------
    assign pair_load = e3_v_reg && e3_second_reg;

    always_comb begin
        pair_next    = pair_reg;
        m_valid_next = m_valid_reg;
        if (cmd.emit_init) begin
            pair_next = '0;
        end else if (pair_load) begin
            pair_next = pair_reg + 1'b1;
        end
        if (pair_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // ---------------- registers ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            falling_reg   <= 1'b0;
            scale_reg     <= setc_pkg::SCALE_0V1;
            level_reg     <= setc_pkg::LEVEL_RESET[SB-1:0];
            issue_cnt_reg <= '0;
            check_cnt_reg <= '0;
            srch_v_reg    <= 1'b0;
            have_cur_reg  <= 1'b0;
            found_reg     <= 1'b0;
            e1_v_reg      <= 1'b0;
            e2_v_reg      <= 1'b0;
            e3_v_reg      <= 1'b0;
            pair_reg      <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            falling_reg   <= falling_next;
            scale_reg     <= scale_next;
            level_reg     <= level_next;
            issue_cnt_reg <= issue_cnt_next;
            check_cnt_reg <= check_cnt_next;
            srch_v_reg    <= srch_issue;
            have_cur_reg  <= have_cur_next;
            found_reg     <= found_next;
            e1_v_reg      <= emit_issue;
            e2_v_reg      <= e1_v_reg;
            e3_v_reg      <= e2_v_reg;
            pair_reg      <= pair_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        addr_reg      <= addr_next;
        srch_addr_reg <= addr_reg;
        e1_second_reg <= cmd.read_second;
        e2_second_reg <= e1_second_reg;
        e3_second_reg <= e2_second_reg;
        if (cmd.search_init) begin
            start_reg <= start_calc;
        end
        if (srch_v_reg) begin
            cur_data_reg <= rd_data;
            cur_addr_reg <= srch_addr_reg;
        end
        if (check_ok && hit) begin
            trig_reg <= cur_addr_reg;
        end
        if (e1_v_reg) begin
            prod_reg   <= PROD_BITS'(mag) * PROD_BITS'(setc_pkg::gain_lookup(scale_reg));
            e2_neg_reg <= diff_neg;
        end
        if (e2_v_reg) begin
            row_reg <= row_calc;
        end
        if (e3_v_reg && !e3_second_reg) begin
            first_hold_reg <= row_reg;
        end
        if (pair_load) begin
            m_pair_reg     <= pair_reg;
            m_y_first_reg  <= first_hold_reg;
            m_y_second_reg <= row_reg;
            m_last_reg     <= (pair_reg == PB'(setc_pkg::PAIR_COUNT - 1));
        end
    end

    assign status.search_done = search_done;
    assign status.out_free    = !m_valid_reg;
    assign status.pair_done   = pair_load;
    assign status.last_pair   = (pair_reg == PB'(setc_pkg::PAIR_COUNT - 1));

    assign m_valid      = m_valid_reg;
    assign m_pair_index = m_pair_reg;
    assign m_y_first    = m_y_first_reg;
    assign m_y_second   = m_y_second_reg;
    assign m_last       = m_last_reg;

`ifndef SYNTHESIS
    // a finished pair must never land on a result still waiting
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        pair_load |-> !m_valid_reg)
        else $error("pair loaded over a pending result");

    // search and emit never share the read port
    a_read_port: assert property (@(posedge aclk) disable iff (!aresetn)
        !(srch_issue && emit_issue))
        else $error("search and emit read in the same cycle");

    // a trigger is only found from a returned search read with a newer sample held
    a_found_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(found_reg) |-> $past(srch_v_reg && have_cur_reg))
        else $error("trigger found without search data");

    // results only go out after the search has finished
    a_emit_after_search: assert property (@(posedge aclk) disable iff (!aresetn)
        emit_issue |-> search_done)
        else $error("emit read before search completion");
`endif

endmodule

`default_nettype wire

### src/scope_edge_trigger_capture.sv
// Oscilloscope edge-trigger capture, top level: sequencer, datapath and sample store.
// Depends on setc_pkg, setc_store, setc_ctrl and setc_dpath.
`default_nettype none

// A sample request (s_func = 0) writes one 12-bit sample into a circular store
// of BUFFER_DEPTH entries and is taken while s_ready is high, so samples stream at
// one per clock while the block is idle. A capture request (s_func = 1) walks
// back from the newest sample minus half a screen over BUFFER_DEPTH/2 positions
// looking for a rising or falling crossing of trigger_level, one store read per
// cycle through the store's single read port, ending early when a crossing
// turns up. It then emits 64 results, each the pixel rows of two neighboring
// columns; every result takes two store reads through a three-stage scale
// pipeline, and a result's reads wait until the one before has left the output
// register. s_ready stays low from the capture request until the last result
// is in the output register. No clearing pass is needed after reset: a fill
// count makes entries not yet written read as zero. Configuration writes are
// taken every cycle and belong in idle periods.
module scope_edge_trigger_capture #(
    parameter int BUFFER_DEPTH = 2048
) (
    input  wire                                    aclk,
    input  wire                                    aresetn,
    input  wire                                    s_valid,
    output logic                                   s_ready,
    input  wire                                    s_func,
    input  wire  [setc_pkg::SAMPLE_BITS-1:0]       s_sample,
    output logic                                   m_valid,
    input  wire                                    m_ready,
    output logic [setc_pkg::PAIR_BITS-1:0]         m_pair_index,
    output logic [setc_pkg::ROW_BITS-1:0]          m_y_first,
    output logic [setc_pkg::ROW_BITS-1:0]          m_y_second,
    output logic                                   m_last,
    input  wire                                    cfg_valid,
    output logic                                   cfg_ready,
    input  wire  [setc_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  wire  [setc_pkg::CFG_DATA_BITS-1:0]     cfg_data
);

    localparam int AW = $clog2(BUFFER_DEPTH);

    setc_pkg::cmd_t    cmd;
    setc_pkg::status_t status;

    logic                          s_take, capture_req, store_req;
    logic                          rd_en;
    logic [AW-1:0]                 rd_addr, wr_ptr;
    logic [setc_pkg::SAMPLE_BITS-1:0] rd_data;

    assign s_take      = s_valid && s_ready;
    assign capture_req = s_take && (s_func == setc_pkg::FUNC_CAPTURE);
    assign store_req   = s_take && (s_func == setc_pkg::FUNC_STORE);
    assign cfg_ready   = 1'b1;

    setc_store #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (store_req),
        .wr_data (s_sample),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_ptr  (wr_ptr)
    );

    setc_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .capture_req (capture_req),
        .status      (status),
        .cmd         (cmd),
        .s_ready     (s_ready)
    );

    setc_dpath #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_dpath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cmd          (cmd),
        .status       (status),
        .wr_ptr       (wr_ptr),
        .rd_en        (rd_en),
        .rd_addr      (rd_addr),
        .rd_data      (rd_data),
        .m_ready      (m_ready),
        .m_valid      (m_valid),
        .m_pair_index (m_pair_index),
        .m_y_first    (m_y_first),
        .m_y_second   (m_y_second),
        .m_last       (m_last)
    );

endmodule

`default_nettype wire
